// ----- sv/rpa_pkg.sv -----
// Shared types, codes and default settings of the reference counted page allocator.
package rpa_pkg;

  localparam int ADDR_W     = 40;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int REF_W      = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_LSB = 3;

  localparam int NUM_PAGES_DEF   = 32768;
  localparam int PAGE_SHIFT_DEF  = 12;
  localparam int COUNT_WIDTH_DEF = 16;

  // Request codes.
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INC   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEC   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_TOP   = 2'd2;

  localparam logic [ADDR_W-1:0] BASE_RST  = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0] START_RST = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0] TOP_RST   = 40'h00_8800_0000;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [ADDR_W-1:0] usable_start;
    logic [ADDR_W-1:0] phys_top;
  } cfg_regs_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [ADDR_W-1:0]       granted_address;
    logic signed [REF_W-1:0] ref_count;
  } result_t;

endpackage

// ----- sv/refcounted_page_allocator_unit.sv -----
// Top level of the reference counted page allocator.
//
// The block hands out physical page frames from a last-in-first-out stack of
// free page indices and keeps a signed reference count for every page. Both
// the stack and the counts live in synchronous RAMs with a registered read.
// Each request word is handled alone: the CHK state checks the address
// against the configured window, the IDX state forms the page index and
// issues the RAM read, the RD state modifies and writes back the count (and
// pushes or pops the stack), and the WAIT state moves the result into the
// output register. in_stall is high while a request is in flight, so no new
// word is taken before the last result reaches the output register.
// A request that touches no RAM word (an alloc on an empty stack, a bad
// address or an unused request code) skips the modify step in the RD state.
// The result register is separate from the working registers, so a new word
// is taken while the previous result still waits on out_stall, and only a
// second finished result has to wait for it. After reset the count RAM is
// swept to zero, one entry a cycle; no request is taken during that sweep,
// but configuration writes are. The free stack starts empty: software frees
// every page once to build the free list. The base, usable start and top
// addresses are written over APB at byte addresses 0, 8 and 16; software must
// write them only while the block is idle, which the block does not enforce.
module refcounted_page_allocator_unit #(
  parameter int NUM_PAGES   = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Request channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rpa_pkg::KIND_W-1:0]            in_kind,
  input  logic [rpa_pkg::ADDR_W-1:0]            in_page_address,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rpa_pkg::STATUS_W-1:0]          out_status,
  output logic [rpa_pkg::ADDR_W-1:0]            out_granted_address,
  output logic signed [rpa_pkg::REF_W-1:0]      out_ref_count,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rpa_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [rpa_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [rpa_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import rpa_pkg::*;

  localparam int IDX_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CHK   = 6'b000100,
    S_IDX   = 6'b001000,
    S_RD    = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  // The count field of a result is the low bits of the count, sign extended
  // when the count is narrower than the port.
  function automatic logic signed [REF_W-1:0] to_ref(
    input logic signed [COUNT_WIDTH-1:0] v
  );
    logic signed [31:0] w;
    w = 32'(v);
    return w[REF_W-1:0];
  endfunction

  cfg_regs_t cfg;

  rpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (cfg)
  );

  // Control state.
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       clr_idx_r, clr_idx_nxt;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Working registers of the request in flight.
  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [ADDR_W-1:0]      addr_r, addr_nxt;
  logic                   win_ok_r, win_ok_nxt;
  logic [ADDR_W-1:0]      off_r, off_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  result_t                res_r, res_nxt;
  result_t                out_r, out_nxt;

  // Memory ports.
  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_waddr, cnt_raddr;
  logic signed [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic                   stk_we;
  logic [IDX_W-1:0]       stk_waddr, stk_raddr;
  logic [IDX_W-1:0]       stk_wdata, stk_rdata;

  rpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (COUNT_WIDTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (IDX_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  logic                   in_fire, out_fire;
  logic [ADDR_W-1:0]      page_no;
  logic                   page_ok;
  logic [DEPTH_W-1:0]     depth_m1;
  logic signed [COUNT_WIDTH-1:0] cnt_inc, cnt_dec;
  logic                   dec_pos;
  logic                   stack_full;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  // The page number is formed from the offset registered in the check cycle.
  assign page_no   = off_r >> PAGE_SHIFT;
  assign page_ok   = win_ok_r && (page_no < ADDR_W'(NUM_PAGES));
  assign depth_m1  = depth_r - DEPTH_W'(1);
  assign stack_full = (depth_r >= DEPTH_W'(NUM_PAGES));

  // Saturating count arithmetic on the word read from the count RAM.
  assign cnt_inc   = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + CNT_ONE;
  assign cnt_dec   = (cnt_rdata == CNT_MIN) ? cnt_rdata : cnt_rdata - CNT_ONE;
  assign dec_pos   = !cnt_dec[COUNT_WIDTH-1] && (cnt_dec != '0);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    depth_nxt     = depth_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    win_ok_nxt    = win_ok_r;
    off_nxt       = off_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;

    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_wdata = '0;
    cnt_raddr = page_no[IDX_W-1:0];
    stk_we    = 1'b0;
    stk_waddr = depth_r[IDX_W-1:0];
    stk_wdata = idx_r;
    stk_raddr = depth_m1[IDX_W-1:0];

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // Sweep the count RAM to zero after reset.
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx_r;
        cnt_wdata = '0;
        if (clr_idx_r == IDX_W'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = in_kind;
          addr_nxt  = in_page_address;
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        // Alignment and window checks, plus the offset from page zero.
        win_ok_nxt = (addr_r[PAGE_SHIFT-1:0] == '0) &&
                     (addr_r >= cfg.usable_start) &&
                     (addr_r < cfg.phys_top) &&
                     (addr_r >= cfg.base_address);
        off_nxt    = addr_r - cfg.base_address;
        state_nxt  = S_IDX;
      end

      S_IDX: begin
        idx_nxt   = page_no[IDX_W-1:0];
        state_nxt = S_RD;
        if (kind_r == KIND_ALLOC) begin
          if (depth_r == '0) begin
            res_nxt   = '{status: ST_EMPTY, granted_address: '0, ref_count: '0};
            state_nxt = S_WAIT;
          end else begin
            // The pop reads the top entry now; its index arrives next cycle.
            depth_nxt = depth_m1;
          end
        end else if (kind_r > KIND_READ) begin
          res_nxt   = '{status: ST_OK, granted_address: '0, ref_count: '0};
          state_nxt = S_WAIT;
        end else if (!page_ok) begin
          res_nxt   = '{status: ST_BAD, granted_address: '0, ref_count: '0};
          state_nxt = S_WAIT;
        end
      end

      S_RD: begin
        state_nxt = S_WAIT;
        res_nxt   = '{status: ST_OK, granted_address: '0, ref_count: to_ref(cnt_rdata)};
        case (kind_r)
          KIND_ALLOC: begin
            cnt_we    = 1'b1;
            cnt_waddr = stk_rdata;
            cnt_wdata = CNT_ONE;
            res_nxt.granted_address = cfg.base_address +
                                      (ADDR_W'(stk_rdata) << PAGE_SHIFT);
            res_nxt.ref_count       = to_ref(CNT_ONE);
          end
          KIND_FREE: begin
            if (dec_pos) begin
              cnt_we            = 1'b1;
              cnt_wdata         = cnt_dec;
              res_nxt.ref_count = to_ref(cnt_dec);
            end else if (stack_full) begin
              // Nothing changes; the count is reported as it stood.
              res_nxt.status = ST_FULL;
            end else begin
              cnt_we            = 1'b1;
              cnt_wdata         = '0;
              stk_we            = 1'b1;
              depth_nxt         = depth_r + DEPTH_W'(1);
              res_nxt.ref_count = '0;
            end
          end
          KIND_INC: begin
            cnt_we            = 1'b1;
            cnt_wdata         = cnt_inc;
            res_nxt.ref_count = to_ref(cnt_inc);
          end
          KIND_DEC: begin
            cnt_we            = 1'b1;
            cnt_wdata         = cnt_dec;
            res_nxt.ref_count = to_ref(cnt_dec);
          end
          default: ;
        endcase
      end

      S_WAIT: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_fire) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    addr_r   <= addr_nxt;
    win_ok_r <= win_ok_nxt;
    off_r    <= off_nxt;
    idx_r    <= idx_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_granted_address = out_r.granted_address;
  assign out_ref_count       = out_r.ref_count;

endmodule

// ----- sv/rpa_ram.sv -----
// Single port write, single port read memory with a registered read.
module rpa_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rpa_cfg.sv -----
// Configuration registers of the page allocator behind an APB-style port.
module rpa_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rpa_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rpa_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rpa_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output rpa_pkg::cfg_regs_t               regs
);
  import rpa_pkg::*;

  cfg_regs_t   regs_r;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign regs    = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.base_address <= BASE_RST;
      regs_r.usable_start <= START_RST;
      regs_r.phys_top     <= TOP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE:  regs_r.base_address <= pwdata[ADDR_W-1:0];
        REG_START: regs_r.usable_start <= pwdata[ADDR_W-1:0];
        REG_TOP:   regs_r.phys_top     <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE:  prdata = CFG_DATA_W'(regs_r.base_address);
      REG_START: prdata = CFG_DATA_W'(regs_r.usable_start);
      REG_TOP:   prdata = CFG_DATA_W'(regs_r.phys_top);
      default:   prdata = '0;
    endcase
  end

endmodule

// ----- test/refcounted_page_allocator_unit_test.sv -----
// Self-checking testbench of the reference counted page allocator.
`timescale 1ns / 100ps

module refcounted_page_allocator_unit_test;
  import rpa_pkg::*;

  localparam int NUM_PAGES   = NUM_PAGES_DEF;
  localparam int PAGE_SHIFT  = PAGE_SHIFT_DEF;
  localparam int IDX_W       = $clog2(NUM_PAGES);
  localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;

  localparam logic signed [REF_W-1:0] CNT_MAX = {1'b0, {(REF_W-1){1'b1}}};
  localparam logic signed [REF_W-1:0] CNT_MIN = {1'b1, {(REF_W-1){1'b0}}};

  // Drain time at the end of each phase, after the last result word is back.
  localparam int DRAIN_CYCLES = 12;
  // Longest quiet stretch of a correct run is the count RAM sweep after reset.
  localparam int WATCHDOG_LIMIT = 200000;

  // Pages used by the count update and repeated free tests; no random phase
  // reaches them.
  localparam int LIMIT_PAGE = 1000;
  localparam int FILL_PAGE  = 2000;

  logic clk;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [KIND_W-1:0]          in_kind = '0;
  logic [ADDR_W-1:0]          in_page_address = '0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic [ADDR_W-1:0]          out_granted_address;
  logic signed [REF_W-1:0]    out_ref_count;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  refcounted_page_allocator_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_page_address     (in_page_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_ref_count       (out_ref_count),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Allocator shadow: the window registers, the free page stack and the count
  // of every page, updated in step with each accepted request word.
  // ---------------------------------------------------------------------------
  cfg_regs_t                window;
  logic [IDX_W-1:0]         free_pages [NUM_PAGES];
  int                       free_count;
  logic signed [REF_W-1:0]  page_refs [NUM_PAGES];

  // Result words that the block still owes, oldest first.
  result_t pending_results [$];

  int error_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  result_t oldest_result;

  initial begin
    window.base_address = BASE_RST;
    window.usable_start = START_RST;
    window.phys_top     = TOP_RST;
    free_count = 0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      page_refs[i] = '0;
    end
  end

  // Works out the result word of one request and applies its effect on the
  // shadow state. Every request gives exactly one result word.
  function automatic result_t predict_result(input logic [KIND_W-1:0] kind,
                                             input logic [ADDR_W-1:0] addr);
    result_t                 r;
    logic [ADDR_W-1:0]       off;
    logic [IDX_W-1:0]        idx;
    logic signed [REF_W-1:0] c;
    logic                    addr_ok;
    r = '0;
    r.status = ST_OK;
    if (kind == KIND_ALLOC) begin
      if (free_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        free_count--;
        idx = free_pages[free_count];
        page_refs[idx] = REF_W'(1);
        r.granted_address = window.base_address + (ADDR_W'(idx) << PAGE_SHIFT);
        r.ref_count = REF_W'(1);
      end
      return r;
    end
    // The three codes above the read request are accepted and do nothing.
    if (kind > KIND_READ) begin
      return r;
    end
    // An address must be aligned, inside [usable_start, phys_top), at or
    // above the base and map to a page index the count RAM holds.
    off = addr - window.base_address;
    addr_ok = (addr[PAGE_SHIFT-1:0] == '0) && (addr >= window.usable_start) &&
              (addr < window.phys_top) && (addr >= window.base_address) &&
              ((off >> PAGE_SHIFT) < NUM_PAGES);
    if (!addr_ok) begin
      r.status = ST_BAD;
      return r;
    end
    idx = off[PAGE_SHIFT +: IDX_W];
    c = page_refs[idx];
    case (kind)
      KIND_FREE: begin
        if (c > CNT_MIN) c--;
        if (c > 0) begin
          // Still referenced: the page stays allocated.
          page_refs[idx] = c;
          r.ref_count = c;
        end else if (free_count >= NUM_PAGES) begin
          // Overflow leaves the count untouched and reports it.
          r.status = ST_FULL;
          r.ref_count = page_refs[idx];
        end else begin
          // Last reference gone, or a double free: the page goes back on the
          // stack either way.
          page_refs[idx] = '0;
          free_pages[free_count] = idx;
          free_count++;
        end
      end
      KIND_INC: begin
        if (c < CNT_MAX) c++;
        page_refs[idx] = c;
        r.ref_count = c;
      end
      KIND_DEC: begin
        if (c > CNT_MIN) c--;
        page_refs[idx] = c;
        r.ref_count = c;
      end
      default: begin
        r.ref_count = c;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and bookkeeping.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Each accepted result word is compared field by field with the oldest
  // expectation. The outputs are sampled at the edge that accepts the word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word arrived with nothing expected");
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_status !== oldest_result.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_status, oldest_result.status));
        end
        if (out_granted_address !== oldest_result.granted_address) begin
          report_mismatch($sformatf("granted_address %h, expected %h",
                                    out_granted_address, oldest_result.granted_address));
        end
        if (out_ref_count !== oldest_result.ref_count) begin
          report_mismatch($sformatf("ref_count %0d, expected %0d",
                                    out_ref_count, oldest_result.ref_count));
        end
      end
    end
  end

  // The result side stalls at random with the probability of the phase.
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: any handshake on either channel or the register port restarts it.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends right after a rising edge, and each
  // signal gets at most one nonblocking assignment per edge.
  // ---------------------------------------------------------------------------
  task automatic set_idling(input int sender_pct, input int receiver_pct);
    gap_pct = sender_pct;
    stall_pct = receiver_pct;
  endtask

  // Sends one request word. Valid stays high from one word to the next when
  // no gap is drawn; during a gap the payload lines carry noise.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) begin
        in_kind <= KIND_W'($urandom);
        in_page_address <= {8'($urandom), 32'($urandom)};
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_page_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(kind, addr));
  endtask

  // Ends a phase: lowers valid and waits until every result word is back.
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then an idle cycle so that
  // back-to-back writes never assign psel twice in one step.
  task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({idx, {CFG_IDX_LSB{1'b0}}});
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BASE:  window.base_address = value;
      REG_START: window.usable_start = value;
      REG_TOP:   window.phys_top = value;
      default:   ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] start,
                            input logic [ADDR_W-1:0] top);
    write_reg(REG_BASE, base);
    write_reg(REG_START, start);
    write_reg(REG_TOP, top);
  endtask

  // Random addresses mostly land on a narrow run of pages so that allocs,
  // frees and count updates keep meeting the same pages; the rest probes the
  // window edges, misalignment and arbitrary 40-bit values.
  function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] lo,
                                                     input int span);
    int                r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    a = lo + (ADDR_W'($urandom_range(0, span - 1)) << PAGE_SHIFT);
    if (r < 72) return a;
    if (r < 80) return a | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
    if (r < 84) return window.usable_start - ADDR_W'(PAGE_BYTES);
    if (r < 88) return window.phys_top;
    if (r < 91) return window.phys_top - ADDR_W'(PAGE_BYTES);
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return KIND_ALLOC;
    if (r < 50) return KIND_FREE;
    if (r < 66) return KIND_INC;
    if (r < 78) return KIND_DEC;
    if (r < 92) return KIND_READ;
    return KIND_READ + KIND_W'($urandom_range(1, 3));
  endfunction

  task automatic run_random(input int count, input logic [ADDR_W-1:0] lo, input int span);
    repeat (count) begin
      send_request(pick_kind(), pick_address(lo, span));
    end
    finish_phase();
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Directed pass over the reset window: empty stack, each request kind, the
  // address checks, double free and the unused request codes. The window is
  // written while the count RAM sweep still runs.
  task automatic test_directed_ops();
    logic [ADDR_W-1:0] first_page;
    logic [ADDR_W-1:0] last_page;
    first_page = BASE_RST;
    last_page = TOP_RST - ADDR_W'(PAGE_BYTES);
    set_idling(0, 0);
    set_window(BASE_RST, START_RST, TOP_RST);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, first_page);
    send_request(KIND_FREE, last_page);
    send_request(KIND_FREE, first_page | ADDR_W'(1));
    send_request(KIND_FREE, TOP_RST);
    send_request(KIND_INC, START_RST - ADDR_W'(PAGE_BYTES));
    send_request(KIND_INC, first_page);
    send_request(KIND_INC, first_page);
    send_request(KIND_READ, first_page);
    send_request(KIND_DEC, first_page);
    send_request(KIND_FREE, first_page);
    send_request(KIND_FREE, first_page);
    send_request(KIND_READ + KIND_W'(1), '1);
    send_request(KIND_READ + KIND_W'(2), '0);
    send_request(KIND_READ + KIND_W'(3), first_page);
    repeat (5) send_request(KIND_ALLOC, '1);
    send_request(KIND_READ, '0);
    send_request(KIND_READ, '1);
    send_request(KIND_DEC, first_page + ADDR_W'(5 * PAGE_BYTES));
    send_request(KIND_READ, first_page + ADDR_W'(5 * PAGE_BYTES));
    send_request(KIND_FREE, first_page + ADDR_W'(5 * PAGE_BYTES));
    finish_phase();
  endtask

  // Random traffic in the reset window with no idling at all.
  task automatic test_random_reset_window();
    set_idling(0, 0);
    run_random(120, BASE_RST, 24);
  endtask

  // A small window with protected pages below usable_start; random words
  // straddle both edges while the sender idles often.
  task automatic test_small_window();
    logic [ADDR_W-1:0] base;
    base = 40'h01_0000_0000;
    set_window(base, base + ADDR_W'(4 * PAGE_BYTES), base + ADDR_W'(40 * PAGE_BYTES));
    set_idling(69, 0);
    run_random(200, base, 44);
  endtask

  // The widest window: zero base and start, top at the last address. Apart from
  // misalignment, only the page index limit rejects addresses; the receiver stalls often.
  task automatic test_wide_window();
    set_window('0, '0, '1);
    set_idling(0, 69);
    run_random(200, ADDR_W'(NUM_PAGES - 20) << PAGE_SHIFT, 40);
  endtask

  // Base near the top of the address space, so granted addresses of pages
  // freed under earlier windows wrap; then a window with top at zero where
  // every address is refused. Both sides idle a little.
  task automatic test_high_base();
    set_window(40'hFF_FFFF_E000, '0, '1);
    set_idling(9, 9);
    run_random(170, 40'hFF_FFFF_C000, 4);
    set_window(40'hFF_FFFF_F000, 40'hFF_FFFF_F000, '0);
    run_random(30, 40'hFF_FFFF_E000, 2);
  endtask

  // A count climbs, falls through zero into negative values, and a free of
  // the page with a negative count still returns it to the stack.
  task automatic test_count_updates();
    logic [ADDR_W-1:0] addr;
    addr = BASE_RST + (ADDR_W'(LIMIT_PAGE) << PAGE_SHIFT);
    set_window(BASE_RST, START_RST, TOP_RST);
    set_idling(0, 0);
    send_request(KIND_READ, addr);
    repeat (6) send_request(KIND_INC, addr);
    repeat (10) send_request(KIND_DEC, addr);
    send_request(KIND_READ, addr);
    send_request(KIND_FREE, addr);
    send_request(KIND_READ, addr);
    send_request(KIND_ALLOC, '0);
    send_request(KIND_READ, addr);
    finish_phase();
  endtask

  // Frees one page over and over so that the stack holds many copies of it,
  // then mixes count updates, a free that only drops a reference, and pops.
  task automatic test_repeated_free();
    logic [ADDR_W-1:0] addr;
    addr = BASE_RST + (ADDR_W'(FILL_PAGE) << PAGE_SHIFT);
    set_idling(0, 0);
    repeat (24) send_request(KIND_FREE, addr);
    set_idling(9, 9);
    repeat (3) send_request(KIND_DEC, addr);
    send_request(KIND_FREE, addr);
    repeat (6) send_request(KIND_INC, addr);
    send_request(KIND_FREE, addr);
    send_request(KIND_READ, addr);
    repeat (3) send_request(KIND_ALLOC, '0);
    send_request(KIND_FREE, addr);
    send_request(KIND_READ, addr);
    finish_phase();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: one reset, then each test in turn.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_random_reset_window();
    test_small_window();
    test_wide_window();
    test_high_base();
    test_count_updates();
    test_repeated_free();
    if (pending_results.size() != 0) begin
      report_mismatch("expected result words left over at the end");
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/rpa_pkg.sv
sv/rpa_ram.sv
sv/rpa_cfg.sv
sv/refcounted_page_allocator_unit.sv
test/refcounted_page_allocator_unit_test.sv
